### hw/rtl/lpfr_pkg.sv
// Shared types and constants for the length-prefixed frame receiver.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package lpfr_pkg;

  // Buffer and header limits.
  localparam int BUFFER_DEPTH     = 4096;
  localparam int MAX_HEADER_BYTES = 4;

  // Widths that follow from the limits above.
  localparam int IDX_W   = $clog2(BUFFER_DEPTH);
  localparam int LEN_W   = IDX_W + 1;
  localparam int ACC_W   = 8 * MAX_HEADER_BYTES;
  localparam int HC_W    = $clog2(MAX_HEADER_BYTES + 1);
  localparam int LANE_W  = 2;
  localparam int CFG_W   = 3;
  localparam int BYTE_W  = 8;

  // Output beat packing: reply byte, store index, store byte, frame length.
  localparam int OUT_FIELDS_W = BYTE_W + IDX_W + BYTE_W + LEN_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
  localparam int OUT_TUSER_W  = 3;

  // Reset value of the header length register.
  localparam logic [CFG_W-1:0] HDR_BYTES_RST = 3'd2;

  // Handshake reply codes.
  localparam logic [BYTE_W-1:0] REPLY_BEGIN = 8'h42;
  localparam logic [BYTE_W-1:0] REPLY_RESET = 8'h52;

  // Input item kinds.
  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  // One result item as it travels from the core to the output stage.
  typedef struct packed {
    logic              reply_valid;
    logic [BYTE_W-1:0] reply_byte;
    logic              store_valid;
    logic [IDX_W-1:0]  store_index;
    logic [BYTE_W-1:0] store_byte;
    logic              frame_done;
    logic [LEN_W-1:0]  frame_length;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/length_prefixed_frame_receiver.sv
// Length-prefixed frame receiver: top level with input register and ports.
// Depends on lpfr_pkg, lpfr_core and lpfr_out_skid.
//
// Usage:
//   The in_ channel carries one beat per received serial byte or release
//   event (in_tuser bit 0: 0 = byte, 1 = release). The first header_bytes
//   bytes of a frame form a little-endian payload length; at header end one
//   reply beat ('B' accepted, 'R' rejected and restarted) is produced, then
//   one store beat per payload byte, the last one also flagging frame_done.
//   Release beats, and header bytes before the last, give no output beat.
//   The cfg_ channel writes header_bytes; write it only while idle. It is
//   always ready and restarts header collection.
//   An accepted input beat is held in the input register, then decoded into
//   the result register. One beat per cycle is sustained while out_tready
//   stays high. When the receiver stalls, a skid stage absorbs one more
//   result and the input register holds one more beat before in_tready
//   drops.
//   Synchronous reset sets header_bytes to 2, clears the frame state and
//   the pending-frame mark, and empties the input and output registers.
`default_nettype none

module length_prefixed_frame_receiver (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input beats.
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [lpfr_pkg::BYTE_W-1:0]      in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]                       in_tuser,   // [0] operation
  // Result beats.
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] reply_byte, [19:8] store_index, [27:20] store_byte,
  // [40:28] frame_length, upper bits zero
  output logic [lpfr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // [0] reply_valid, [1] store_valid, [2] frame_done
  output logic [lpfr_pkg::OUT_TUSER_W-1:0]      out_tuser,
  // Configuration write.
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lpfr_pkg::CFG_W-1:0]       cfg_data
);

  logic                        s1_valid_r;
  logic                        s1_op_r;
  logic [lpfr_pkg::BYTE_W-1:0] s1_byte_r;
  logic                        res_ready;
  logic                        take;
  logic                        res_valid;
  lpfr_pkg::res_t              res;
  lpfr_pkg::res_t              out_res;

  assign cfg_ready = 1'b1;
  assign take      = s1_valid_r && res_ready;
  assign in_tready = !s1_valid_r || take;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser[0];
      s1_byte_r <= in_tdata;
    end
  end

  lpfr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_wdata (cfg_data),
    .item_fire (take),
    .item_op   (lpfr_pkg::op_t'(s1_op_r)),
    .item_byte (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  lpfr_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_data  (res),
    .push_ready (res_ready),
    .out_valid  (out_tvalid),
    .out_data   (out_res),
    .out_ready  (out_tready)
  );

  // Pack the result beat.
  assign out_tdata = {{lpfr_pkg::OUT_PAD_W{1'b0}}, out_res.frame_length,
                      out_res.store_byte, out_res.store_index, out_res.reply_byte};
  assign out_tuser = {out_res.frame_done, out_res.store_valid, out_res.reply_valid};

  // Every result is either a reply or a buffer write, never both.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] ^ out_tuser[1]))
    else $error("result beat is neither or both of reply and store");

  // The write that completes a frame is at its last buffer position.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1] && out_tuser[2]) |->
      (({1'b0, out_tdata[19:8]} + 13'd1) == out_tdata[40:28]))
    else $error("frame completion not on the last payload byte");

  // A frame completed by its reply is an accepted empty frame.
  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0] && out_tuser[2]) |->
      ((out_tdata[7:0] == lpfr_pkg::REPLY_BEGIN) && (out_tdata[40:28] == '0)))
    else $error("completion on a reply that does not accept an empty frame");

endmodule

`default_nettype wire

### hw/rtl/lpfr_core.sv
// Frame state and per-beat decode of the length-prefixed frame receiver.
// Depends on lpfr_pkg for widths, reply codes and the result struct.
`default_nettype none

module lpfr_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [lpfr_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic                        item_fire,
  input  wire lpfr_pkg::op_t               item_op,
  input  wire logic [lpfr_pkg::BYTE_W-1:0] item_byte,
  output logic                             res_valid,
  output lpfr_pkg::res_t                   res
);

  logic [lpfr_pkg::CFG_W-1:0] hb_r, hb_nxt;
  logic [lpfr_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [lpfr_pkg::HC_W-1:0]  hc_r, hc_nxt;
  logic [lpfr_pkg::LEN_W-1:0] pc_r, pc_nxt;
  logic                       pending_r, pending_nxt;

  logic [lpfr_pkg::HC_W-1:0]  hb_eff;
  logic [lpfr_pkg::HC_W-1:0]  hc_inc;
  logic [lpfr_pkg::ACC_W-1:0] acc_hdr;
  logic [lpfr_pkg::LEN_W-1:0] pc_inc;

  // Effective header length: zero acts as one, large values are clamped.
  always_comb begin
    if (hb_r == '0) begin
      hb_eff = lpfr_pkg::HC_W'(1);
    end else if (32'(hb_r) > lpfr_pkg::MAX_HEADER_BYTES) begin
      hb_eff = lpfr_pkg::HC_W'(lpfr_pkg::MAX_HEADER_BYTES);
    end else begin
      hb_eff = lpfr_pkg::HC_W'(hb_r);
    end
  end

  // Header byte lands in its little-endian lane of the accumulator.
  assign acc_hdr = acc_r | (lpfr_pkg::ACC_W'(item_byte)
                            << {hc_r[lpfr_pkg::LANE_W-1:0], 3'b000});
  assign hc_inc  = hc_r + lpfr_pkg::HC_W'(1);
  assign pc_inc  = pc_r + lpfr_pkg::LEN_W'(1);

  // Next state and result for one beat.
  always_comb begin
    hb_nxt      = hb_r;
    acc_nxt     = acc_r;
    hc_nxt      = hc_r;
    pc_nxt      = pc_r;
    pending_nxt = pending_r;
    res_valid   = 1'b0;
    res         = '0;

    if (cfg_we) begin
      // A new header length restarts collection; a pending frame is kept.
      hb_nxt  = cfg_wdata;
      acc_nxt = '0;
      hc_nxt  = '0;
      pc_nxt  = '0;
    end else if (item_fire) begin
      if (item_op == lpfr_pkg::OP_RELEASE) begin
        pending_nxt = 1'b0;
      end else if (hc_r < hb_eff) begin
        // Header phase.
        acc_nxt = acc_hdr;
        hc_nxt  = hc_inc;
        if (hc_inc == hb_eff) begin
          res_valid       = 1'b1;
          res.reply_valid = 1'b1;
          if (pending_r || (acc_hdr > lpfr_pkg::ACC_W'(lpfr_pkg::BUFFER_DEPTH))) begin
            // Previous frame unreleased or length too large: reject.
            res.reply_byte = lpfr_pkg::REPLY_RESET;
            acc_nxt        = '0;
            hc_nxt         = '0;
            pc_nxt         = '0;
          end else if (acc_hdr == '0) begin
            // An empty frame completes at once.
            res.reply_byte = lpfr_pkg::REPLY_BEGIN;
            res.frame_done = 1'b1;
            pending_nxt    = 1'b1;
            acc_nxt        = '0;
            hc_nxt         = '0;
            pc_nxt         = '0;
          end else begin
            res.reply_byte = lpfr_pkg::REPLY_BEGIN;
            pc_nxt         = '0;
          end
        end
      end else begin
        // Payload phase: every byte becomes a buffer write.
        res_valid       = 1'b1;
        res.store_valid = 1'b1;
        res.store_index = pc_r[lpfr_pkg::IDX_W-1:0];
        res.store_byte  = item_byte;
        pc_nxt          = pc_inc;
        if (lpfr_pkg::ACC_W'(pc_inc) >= acc_r) begin
          res.frame_done   = 1'b1;
          res.frame_length = acc_r[lpfr_pkg::LEN_W-1:0];
          pending_nxt      = 1'b1;
          acc_nxt          = '0;
          hc_nxt           = '0;
          pc_nxt           = '0;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_r      <= lpfr_pkg::HDR_BYTES_RST;
      acc_r     <= '0;
      hc_r      <= '0;
      pc_r      <= '0;
      pending_r <= 1'b0;
    end else begin
      hb_r      <= hb_nxt;
      acc_r     <= acc_nxt;
      hc_r      <= hc_nxt;
      pc_r      <= pc_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lpfr_out_skid.sv
// Result register with a skid stage for the frame receiver's output beats.
// Depends on lpfr_pkg for the result struct.
`default_nettype none

module lpfr_out_skid (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  input  wire lpfr_pkg::res_t push_data,
  output logic                push_ready,
  output logic                out_valid,
  output lpfr_pkg::res_t      out_data,
  input  wire logic           out_ready
);

  logic           main_valid_r, main_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  lpfr_pkg::res_t main_r, main_nxt;
  lpfr_pkg::res_t skid_r, skid_nxt;
  logic           pop;

  // Ready comes from a register, so no path runs from out_ready upstream.
  assign push_ready = !skid_valid_r;
  assign pop        = main_valid_r && out_ready;
  assign out_valid  = main_valid_r;
  assign out_data   = main_r;

  // Move beats between the skid and the main register.
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push_valid) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  // Valid flags are reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

### dv/length_prefixed_frame_receiver_tb.sv
// Self-checking testbench for the length-prefixed frame receiver.
// Drives header, payload and release beats, and checks every reply and store
// beat against a cycle-free model of the deframer. Depends on lpfr_pkg.
`timescale 1ns / 100ps

module length_prefixed_frame_receiver_tb;
  import lpfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BEATS    = 150;
  localparam int REPORT_MAX     = 10;

  // One input beat: a received byte or a release.
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } rx_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = HDR_BYTES_RST;

  // Beats waiting to be driven and outcomes waiting to be seen.
  rx_beat_t rx_beat_q[$];
  res_t     rx_outcome_q[$];

  // Model state of the deframer.
  logic [CFG_W-1:0] hdr_cfg_m = HDR_BYTES_RST;
  logic [31:0]      len_acc = '0;
  int unsigned      hdr_seen = 0;
  int unsigned      pay_seen = 0;
  logic             frame_held = 1'b0;

  int          send_idle_pct = 11;
  int          recv_stall_pct = 85;
  logic        send_hold = 1'b0;
  int unsigned beats_sent = 0;
  int unsigned fail_cnt = 0;
  int unsigned quiet_cycles = 0;

  logic [CFG_W-1:0] cfg_seq [8] = '{3'd1, 3'd4, 3'd2, 3'd7, 3'd3, 3'd0, 3'd5, 3'd6};

  length_prefixed_frame_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Header length in force for a register value: zero acts as one byte and
  // anything past the maximum is clamped.
  function automatic int unsigned hdr_len_eff(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_HEADER_BYTES) return MAX_HEADER_BYTES;
    return 32'(v);
  endfunction

  function automatic void clear_frame();
    len_acc  = '0;
    hdr_seen = 0;
    pay_seen = 0;
  endfunction

  function automatic string fmt_res(input res_t r);
    return $sformatf("reply %0b/%h store %0b/%0d/%h done %0b/%0d", r.reply_valid,
                     r.reply_byte, r.store_valid, r.store_index, r.store_byte,
                     r.frame_done, r.frame_length);
  endfunction

  // Works out what one accepted beat produces and queues it, if anything.
  task automatic decode_rx_beat(input op_t op, input logic [BYTE_W-1:0] b);
    res_t r;
    int unsigned hb;
    r  = '0;
    hb = hdr_len_eff(hdr_cfg_m);
    if (op == OP_RELEASE) begin
      frame_held = 1'b0;
      return;
    end
    if (hdr_seen < hb) begin
      len_acc = len_acc | (32'(b) << (8 * (hdr_seen % 4)));
      hdr_seen++;
      if (hdr_seen < hb) return;
      r.reply_valid = 1'b1;
      if (frame_held || len_acc > BUFFER_DEPTH) begin
        r.reply_byte = REPLY_RESET;
        clear_frame();
      end else if (len_acc == '0) begin
        // An empty frame is begun and completed by the same beat.
        r.reply_byte = REPLY_BEGIN;
        r.frame_done = 1'b1;
        frame_held   = 1'b1;
        clear_frame();
      end else begin
        r.reply_byte = REPLY_BEGIN;
        pay_seen     = 0;
      end
    end else begin
      r.store_valid = 1'b1;
      r.store_index = pay_seen[IDX_W-1:0];
      r.store_byte  = b;
      pay_seen++;
      if (pay_seen >= len_acc) begin
        r.frame_done   = 1'b1;
        r.frame_length = len_acc[LEN_W-1:0];
        frame_held     = 1'b1;
        clear_frame();
      end
    end
    rx_outcome_q.push_back(r);
  endtask

  task automatic note_fail(input string what, input res_t want, input res_t got);
    fail_cnt++;
    if (fail_cnt <= REPORT_MAX)
      $display("%0t %s: expected %s, got %s", $realtime, what, fmt_res(want), fmt_res(got));
  endtask

  // Input driver: a new beat is offered once the previous one has gone.
  always @(posedge clk) begin : drive_in
    rx_beat_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) decode_rx_beat(op_t'(in_tuser[0]), in_tdata);
      if (!in_tvalid || in_tready) begin
        if (rx_beat_q.size() != 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          nxt = rx_beat_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.data;
          in_tuser  <= nxt.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: stalls at random and checks each accepted beat.
  always @(posedge clk) begin : watch_out
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.reply_valid  = out_tuser[0];
        got.store_valid  = out_tuser[1];
        got.frame_done   = out_tuser[2];
        got.reply_byte   = out_tdata[7:0];
        got.store_index  = out_tdata[19:8];
        got.store_byte   = out_tdata[27:20];
        got.frame_length = out_tdata[40:28];
        if (rx_outcome_q.size() == 0) begin
          note_fail("unexpected beat", '0, got);
        end else begin
          want = rx_outcome_q.pop_front();
          if (got.reply_valid !== want.reply_valid || got.reply_byte !== want.reply_byte ||
              got.store_valid !== want.store_valid || got.store_index !== want.store_index ||
              got.store_byte !== want.store_byte || got.frame_done !== want.frame_done ||
              got.frame_length !== want.frame_length)
            note_fail("mismatch", want, got);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run if no beat of any kind moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_beat(input op_t op, input logic [BYTE_W-1:0] b);
    rx_beat_q.push_back('{op: op, data: b});
    beats_sent++;
  endtask

  task automatic push_rx(input logic [BYTE_W-1:0] b);
    push_beat(OP_BYTE, b);
  endtask

  task automatic push_release();
    push_beat(OP_RELEASE, 8'($urandom));
  endtask

  // Waits until every beat is sent and answered, then lets trailing header
  // bytes, which produce nothing, clear the pipeline.
  task automatic settle();
    while (rx_beat_q.size() != 0 || in_tvalid || rx_outcome_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_hdr_cfg(input logic [CFG_W-1:0] v);
    settle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hdr_cfg_m = v;
    clear_frame();
  endtask

  task automatic set_pace(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // The sender stops with beats still queued until every outcome is in.
  task automatic hold_sender_until_drained();
    @(posedge clk);
    send_hold <= 1'b1;
    do @(posedge clk); while (in_tvalid || rx_outcome_q.size() != 0);
    send_hold <= 1'b0;
  endtask

  // One frame with random content; a minority are oversized, truncated,
  // sent without a release, or just stray beats.
  task automatic push_random_frame(input int unsigned eff);
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    logic [31:0] hdr;
    kind = $urandom_range(99);
    if (kind < 6) begin
      repeat ($urandom_range(5, 1)) push_beat(op_t'($urandom_range(1)), 8'($urandom));
      return;
    end
    if ($urandom_range(99) < 85) push_release();
    if (kind < 14 && eff > 1) begin
      // Length above the buffer capacity.
      case (eff)
        2:       hdr = $urandom_range(32'hFFFF, BUFFER_DEPTH + 1);
        3:       hdr = $urandom_range(32'hFF_FFFF, BUFFER_DEPTH + 1);
        default: hdr = $urandom_range(32'hFFFF_FFFF, BUFFER_DEPTH + 1);
      endcase
      len = 0;
    end else if (kind < 24) begin
      hdr = '0;
      len = 0;
    end else begin
      if ($urandom_range(99) < 8) len = $urandom_range((eff == 1) ? 255 : 300, 17);
      else len = $urandom_range(16, 1);
      hdr = len;
    end
    for (int k = 0; k < eff; k++) push_rx(hdr[8*k +: 8]);
    // Truncated frames leave the rest to be taken from the next frame.
    cut = (kind < 30) ? $urandom_range(len) : len;
    for (int k = 0; k < cut; k++) begin
      if ($urandom_range(99) < 4) push_release();
      push_rx(8'($urandom));
    end
  endtask

  initial begin : run
    int unsigned phase_no;
    int unsigned mark;
    logic [CFG_W-1:0] next_cfg;
    phase_no = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting with the reset header length of two bytes.
    push_rx(8'h00); push_rx(8'h00);            // empty frame completes at once
    push_rx(8'h01); push_rx(8'h00);            // previous frame not released
    push_release(); push_release();            // second release finds nothing held
    push_rx(8'h01); push_rx(8'h10);            // one past the buffer capacity
    push_rx(8'h00); push_rx(8'h10);            // full buffer accepted, payload cut
    write_hdr_cfg(3'd0);                       // zero acts as one header byte
    push_rx(8'h02); push_rx(8'hAA);
    push_release();                            // release in the middle of a frame
    push_rx(8'h55);
    push_rx(8'h00);                            // refused while still held
    write_hdr_cfg(3'd7);                       // clamped to four header bytes
    push_release();
    push_rx(8'hFF); push_rx(8'hFF); push_rx(8'hFF); push_rx(8'hFF);
    push_rx(8'h05);                            // header left half written
    write_hdr_cfg(3'd4);
    push_rx(8'h01); push_rx(8'h00); push_rx(8'h00); push_rx(8'h00);
    push_rx(8'h80);

    // Random part in three pacing stages.
    for (int st = 0; st < 3; st++) begin
      case (st)
        0:       set_pace(11, 85);
        1:       set_pace(85, 11);
        default: set_pace(0, 0);
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        next_cfg = (phase_no < 8) ? cfg_seq[phase_no] : CFG_W'($urandom_range(7));
        write_hdr_cfg(next_cfg);
        mark = beats_sent;
        while (beats_sent - mark < PHASE_BEATS) push_random_frame(hdr_len_eff(hdr_cfg_m));
        if (st == 0 && ph == 1) begin
          while (rx_beat_q.size() > PHASE_BEATS / 2) @(posedge clk);
          hold_sender_until_drained();
        end
        phase_no++;
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0 && rx_outcome_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
